### hdl/mnp_pkg.sv
package mnp_pkg;

   localparam int NUM_PITCHES = 128;
   localparam int TIME_BITS   = 40;

   localparam int PITCH_W     = 7;
   localparam int VEL_W       = 7;
   localparam int DELTA_W     = 28;
   localparam int TICK_W      = 40;
   localparam int PIDX_W      = (NUM_PITCHES > 1) ? $clog2(NUM_PITCHES) : 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // table entry: start tick above, volume below
   localparam int ENTRY_W     = TIME_BITS + VEL_W;

   typedef enum logic [1:0] {
      OP_NOTE_ON  = 2'd0,
      OP_NOTE_OFF = 2'd1,
      OP_DAMPER   = 2'd2,
      OP_FLUSH    = 2'd3
   } op_type;

   // classified item handed from the front to the back
   typedef struct packed {
      op_type                 op;
      logic [PITCH_W-1:0]     pitch;
      logic [VEL_W-1:0]       velocity;
      logic                   damper_value;
      logic [TIME_BITS-1:0]   tick;
   } evt_type;

   // absolute time to the 40-bit output tick
   function automatic logic [TICK_W-1:0] to_tick(input logic [TIME_BITS-1:0] t);
      logic [TIME_BITS+TICK_W-1:0] wide;
      wide = {{TICK_W{1'b0}}, t};
      return wide[TICK_W-1:0];
   endfunction

endpackage

### hdl/midi_event_to_note_pairing_unit.sv
// MIDI note on/off pairing unit.
// Input channel (req_*): one event per item: operation (note on, note off,
// damper, flush), delta ticks, pitch, velocity and damper value.
// Output channel (rsp_*): one completed note or pedal interval per item,
// with pitch, volume, start tick and stop tick; a note-on, a damper open
// and any close with nothing open produce no item.
// Both channels: an item moves on a clock edge with valid high and stall
// low. Valid never looks at stall.
// An accepted event is written into the queue, then popped by the back into
// the output register, which drives rsp_valid.
// Throughput: one event per clock, sustained while rsp_stall is low.
// The front advances the saturating tick counter on each accept but a flush
// and drops the event into a two-entry queue; the back owns the per-pitch
// table (at most one memory read or write per event) and the output register.
// A stalled receiver holds a pending result; the back stops, the queue
// fills, and after at most two more events req_stall rises.
// Reset (synchronous): time is zero, all notes and the pedal are closed,
// queue and output are empty. No clearing pass is needed.
module midi_event_to_note_pairing_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_operation,
   input  logic [mnp_pkg::DELTA_W-1:0] req_delta_ticks,
   input  logic [mnp_pkg::PITCH_W-1:0] req_pitch,
   input  logic [mnp_pkg::VEL_W-1:0]   req_velocity,
   input  logic                        req_damper_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_is_damper,
   output logic [mnp_pkg::PITCH_W-1:0] rsp_note_pitch,
   output logic [mnp_pkg::VEL_W-1:0]   rsp_note_volume,
   output logic [mnp_pkg::TICK_W-1:0]  rsp_start_tick,
   output logic [mnp_pkg::TICK_W-1:0]  rsp_stop_tick
);
   import mnp_pkg::*;

   // front to queue
   logic    push;
   evt_type push_evt;
   logic    queue_full;

   // queue to back
   logic    head_valid;
   evt_type head_evt;
   logic    pop;

   // time keeping and classification
   mnp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_delta_ticks  (req_delta_ticks),
      .req_pitch        (req_pitch),
      .req_velocity     (req_velocity),
      .req_damper_value (req_damper_value),
      .queue_full       (queue_full),
      .push             (push),
      .push_evt         (push_evt)
   );

   // decouples the two halves so each can stall on its own
   mnp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_evt   (push_evt),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_evt   (head_evt)
   );

   // note table, pedal state and result register
   mnp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_evt        (head_evt),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_is_damper   (rsp_is_damper),
      .rsp_note_pitch  (rsp_note_pitch),
      .rsp_note_volume (rsp_note_volume),
      .rsp_start_tick  (rsp_start_tick),
      .rsp_stop_tick   (rsp_stop_tick)
   );

endmodule

### hdl/mnp_ram.sv
module mnp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/mnp_front.sv
module mnp_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_operation,
   input  logic [mnp_pkg::DELTA_W-1:0] req_delta_ticks,
   input  logic [mnp_pkg::PITCH_W-1:0] req_pitch,
   input  logic [mnp_pkg::VEL_W-1:0]   req_velocity,
   input  logic                      req_damper_value,
   input  logic                      queue_full,
   output logic                      push,
   output mnp_pkg::evt_type          push_evt
);
   import mnp_pkg::*;

   localparam int SUM_W = ((TIME_BITS > DELTA_W) ? TIME_BITS : DELTA_W) + 1;
   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

   logic [TIME_BITS-1:0] time_ff, time_in;
   logic [SUM_W-1:0]     sum;
   logic [TIME_BITS-1:0] advanced;
   op_type               op;

   assign op        = op_type'(req_operation);
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // saturating time advance
   always_comb begin
      sum = SUM_W'(time_ff) + SUM_W'(req_delta_ticks);
      if (sum > SUM_W'(TIME_MAX)) begin
         advanced = TIME_MAX;
      end else begin
         advanced = sum[TIME_BITS-1:0];
      end
   end

   always_comb begin
      time_in = time_ff;
      if (push && op != OP_FLUSH) begin
         time_in = advanced;
      end
   end

   always_comb begin
      push_evt.op           = op;
      push_evt.pitch        = req_pitch;
      push_evt.velocity     = req_velocity;
      push_evt.damper_value = req_damper_value;
      push_evt.tick         = (op == OP_FLUSH) ? time_ff : advanced;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff <= '0;
      end else begin
         time_ff <= time_in;
      end
   end

endmodule

### hdl/mnp_queue.sv
module mnp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mnp_pkg::evt_type push_evt,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output mnp_pkg::evt_type head_evt
);
   import mnp_pkg::*;

   evt_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_evt   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_evt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### hdl/mnp_back.sv
module mnp_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        head_valid,
   input  mnp_pkg::evt_type            head_evt,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_is_damper,
   output logic [mnp_pkg::PITCH_W-1:0] rsp_note_pitch,
   output logic [mnp_pkg::VEL_W-1:0]   rsp_note_volume,
   output logic [mnp_pkg::TICK_W-1:0]  rsp_start_tick,
   output logic [mnp_pkg::TICK_W-1:0]  rsp_stop_tick
);
   import mnp_pkg::*;

   logic [NUM_PITCHES-1:0] open_ff, open_in;
   logic                   pedal_open_ff, pedal_open_in;
   logic [TIME_BITS-1:0]   pedal_start_ff, pedal_start_in;

   // result register; volume and start of a note come from the table read
   logic                   res_valid_ff, res_valid_in;
   logic                   res_damper_ff;
   logic [PITCH_W-1:0]     res_pitch_ff;
   logic [TIME_BITS-1:0]   res_stop_ff;
   logic [TIME_BITS-1:0]   res_pstart_ff;

   logic                   in_range;
   logic [PIDX_W-1:0]      idx;
   logic                   has_result;
   logic                   wr_en, rd_en;
   logic [ENTRY_W-1:0]     wr_data, rd_data;

   assign pop      = head_valid && (!res_valid_ff || !rsp_stall);
   assign in_range = (32'(head_evt.pitch) < 32'(NUM_PITCHES));
   assign idx      = head_evt.pitch[PIDX_W-1:0];
   assign wr_data  = {head_evt.tick, head_evt.velocity};

   always_comb begin
      open_in        = open_ff;
      pedal_open_in  = pedal_open_ff;
      pedal_start_in = pedal_start_ff;
      has_result     = 1'b0;
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      if (pop) begin
         unique case (head_evt.op)
            OP_NOTE_ON: begin
               if (in_range) begin
                  open_in[idx] = 1'b1;
                  wr_en        = 1'b1;
               end
            end
            OP_NOTE_OFF, OP_FLUSH: begin
               if (in_range && open_ff[idx]) begin
                  open_in[idx] = 1'b0;
                  rd_en        = 1'b1;
                  has_result   = 1'b1;
               end
            end
            OP_DAMPER: begin
               if (head_evt.damper_value) begin
                  pedal_open_in  = 1'b1;
                  pedal_start_in = head_evt.tick;
               end else if (pedal_open_ff) begin
                  pedal_open_in = 1'b0;
                  has_result    = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (pop) begin
         res_valid_in = has_result;
      end else if (!rsp_stall) begin
         res_valid_in = 1'b0;
      end else begin
         res_valid_in = res_valid_ff;
      end
   end

   mnp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_PITCHES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff       <= '0;
         pedal_open_ff <= 1'b0;
         res_valid_ff  <= 1'b0;
      end else begin
         open_ff       <= open_in;
         pedal_open_ff <= pedal_open_in;
         res_valid_ff  <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pedal_start_ff <= pedal_start_in;
      if (pop) begin
         res_damper_ff <= (head_evt.op == OP_DAMPER);
         res_pitch_ff  <= head_evt.pitch;
         res_stop_ff   <= head_evt.tick;
         res_pstart_ff <= pedal_start_ff;
      end
   end

   assign rsp_valid       = res_valid_ff;
   assign rsp_is_damper   = res_damper_ff;
   assign rsp_note_pitch  = res_damper_ff ? '0 : res_pitch_ff;
   assign rsp_note_volume = res_damper_ff ? '0 : rd_data[VEL_W-1:0];
   assign rsp_start_tick  = res_damper_ff ? to_tick(res_pstart_ff)
                                          : to_tick(rd_data[ENTRY_W-1:VEL_W]);
   assign rsp_stop_tick   = to_tick(res_stop_ff);

endmodule

### sim/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import mnp_pkg::*;

   // one event as it goes onto the request port
   typedef struct packed {
      op_type               op;
      logic [DELTA_W-1:0]   delta;
      logic [PITCH_W-1:0]   pitch;
      logic [VEL_W-1:0]     velocity;
      logic                 damper_value;
   } midi_event_type;

   // one completed note or pedal interval
   typedef struct packed {
      logic                 is_damper;
      logic [PITCH_W-1:0]   pitch;
      logic [VEL_W-1:0]     volume;
      logic [TICK_W-1:0]    start;
      logic [TICK_W-1:0]    stop;
   } closed_note_type;

   localparam logic [TIME_BITS-1:0] SONG_END   = '1;   // saturated absolute time
   localparam logic [DELTA_W-1:0]   DELTA_TOP  = '1;
   localparam int                   CLIMB_LEN  = 300;  // run of max deltas
   localparam int                   RANDOM_LEN = 1000;
   localparam int                   TAIL_LEN   = 120;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_valid        = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_operation    = '0;
   logic [DELTA_W-1:0]    req_delta_ticks  = '0;
   logic [PITCH_W-1:0]    req_pitch        = '0;
   logic [VEL_W-1:0]      req_velocity     = '0;
   logic                  req_damper_value = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall        = 1'b0;
   logic                  rsp_is_damper;
   logic [PITCH_W-1:0]    rsp_note_pitch;
   logic [VEL_W-1:0]      rsp_note_volume;
   logic [TICK_W-1:0]     rsp_start_tick;
   logic [TICK_W-1:0]     rsp_stop_tick;

   midi_event_to_note_pairing_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_delta_ticks  (req_delta_ticks),
      .req_pitch        (req_pitch),
      .req_velocity     (req_velocity),
      .req_damper_value (req_damper_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_is_damper    (rsp_is_damper),
      .rsp_note_pitch   (rsp_note_pitch),
      .rsp_note_volume  (rsp_note_volume),
      .rsp_start_tick   (rsp_start_tick),
      .rsp_stop_tick    (rsp_stop_tick)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Note pairing tracker: our own copy of the block's state, stepped
   // once per accepted item, in accept order.
   // ------------------------------------------------------------------
   logic [TIME_BITS-1:0]  song_tick;
   bit                    held      [NUM_PITCHES];
   logic [TIME_BITS-1:0]  held_start[NUM_PITCHES];
   logic [VEL_W-1:0]      held_volume[NUM_PITCHES];
   bit                    pedal_down;
   logic [TIME_BITS-1:0]  pedal_since;

   closed_note_type       expected_notes[$];
   midi_event_type        pending_events[$];

   int                    mismatch_count = 0;

   initial begin
      song_tick  = '0;
      pedal_down = 1'b0;
      pedal_since = '0;
      for (int i = 0; i < NUM_PITCHES; i++) begin
         held[i]        = 1'b0;
         held_start[i]  = '0;
         held_volume[i] = '0;
      end
   end

   function automatic void pair_event(input midi_event_type ev, output bit emitted,
                                      output closed_note_type res);
      logic [TIME_BITS:0] sum;
      emitted = 1'b0;
      res     = '0;
      // flush is the only op that leaves time alone; time saturates
      if (ev.op != OP_FLUSH) begin
         sum = {1'b0, song_tick} + (TIME_BITS+1)'(ev.delta);
         if (sum > {1'b0, SONG_END})
            song_tick = SONG_END;
         else
            song_tick = sum[TIME_BITS-1:0];
      end
      case (ev.op)
         OP_NOTE_ON: begin
            // re-strike on an open pitch just overwrites, nothing emitted
            if (ev.pitch < NUM_PITCHES) begin
               held[ev.pitch]        = 1'b1;
               held_start[ev.pitch]  = song_tick;
               held_volume[ev.pitch] = ev.velocity;
            end
         end
         OP_NOTE_OFF, OP_FLUSH: begin
            if (ev.pitch < NUM_PITCHES && held[ev.pitch]) begin
               emitted       = 1'b1;
               res.is_damper = 1'b0;
               res.pitch     = ev.pitch;
               res.volume    = held_volume[ev.pitch];
               res.start     = TICK_W'(held_start[ev.pitch]);
               res.stop      = TICK_W'(song_tick);
               held[ev.pitch] = 1'b0;
            end
         end
         default: begin
            if (ev.damper_value) begin
               // pedal down again while down restarts the interval
               pedal_down  = 1'b1;
               pedal_since = song_tick;
            end else if (pedal_down) begin
               emitted       = 1'b1;
               res.is_damper = 1'b1;
               res.start     = TICK_W'(pedal_since);
               res.stop      = TICK_W'(song_tick);
               pedal_down    = 1'b0;
            end
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Stimulus building. The generator keeps its own view of which pitches
   // and whether the pedal are open, so most offs and flushes land on
   // open notes and most pedal events alternate.
   // ------------------------------------------------------------------
   bit                    gen_open[NUM_PITCHES];
   bit                    gen_pedal = 1'b0;
   logic [PITCH_W-1:0]    pitch_pool[16];

   task automatic add_event(input op_type op, input logic [DELTA_W-1:0] delta,
                            input logic [PITCH_W-1:0] pitch,
                            input logic [VEL_W-1:0] velocity, input logic dval);
      midi_event_type ev;
      ev.op           = op;
      ev.delta        = delta;
      ev.pitch        = pitch;
      ev.velocity     = velocity;
      ev.damper_value = dval;
      case (op)
         OP_NOTE_ON:            gen_open[pitch] = 1'b1;
         OP_NOTE_OFF, OP_FLUSH: gen_open[pitch] = 1'b0;
         default:               gen_pedal = dval;
      endcase
      pending_events.insert(pending_events.size(), ev);
   endtask

   function automatic logic [DELTA_W-1:0] random_delta();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30)      return DELTA_W'($urandom_range(0, 15));
      else if (r < 65) return DELTA_W'($urandom_range(0, 65535));
      else if (r < 90) return DELTA_W'($urandom());
      else             return DELTA_TOP - DELTA_W'($urandom_range(0, 3));
   endfunction

   // open pitch if any (most of the time), else any pitch
   function automatic logic [PITCH_W-1:0] pick_close_pitch(input int open_pct);
      int n;
      int k;
      n = 0;
      for (int i = 0; i < NUM_PITCHES; i++)
         if (gen_open[i]) n++;
      if (n == 0 || $urandom_range(0, 99) >= open_pct)
         return PITCH_W'($urandom_range(0, NUM_PITCHES - 1));
      k = $urandom_range(0, n - 1);
      for (int i = 0; i < NUM_PITCHES; i++) begin
         if (gen_open[i]) begin
            if (k == 0) return PITCH_W'(i);
            k--;
         end
      end
      return '0;
   endfunction

   task automatic add_random_event(input bit climb);
      logic [DELTA_W-1:0] delta;
      logic [PITCH_W-1:0] pitch;
      logic [VEL_W-1:0]   vel;
      logic               dval;
      op_type             op;
      int                 r;
      delta = climb ? DELTA_TOP : random_delta();
      vel   = VEL_W'($urandom());
      dval  = 1'($urandom());
      r     = $urandom_range(0, 99);
      if (r < 8) begin
         // noise: any op, any pitch
         op    = op_type'($urandom_range(0, 3));
         pitch = PITCH_W'($urandom());
      end else if (r < 40) begin
         op    = OP_NOTE_ON;
         pitch = ($urandom_range(0, 3) != 0) ? pitch_pool[$urandom_range(0, 15)]
                                             : PITCH_W'($urandom());
      end else if (r < 72) begin
         op    = OP_NOTE_OFF;
         pitch = pick_close_pitch(85);
      end else if (r < 88) begin
         op    = OP_DAMPER;
         pitch = PITCH_W'($urandom());
         dval  = ($urandom_range(0, 99) < 80) ? !gen_pedal : gen_pedal;
      end else begin
         op    = OP_FLUSH;
         pitch = pick_close_pitch(70);
      end
      add_event(op, delta, pitch, vel, dval);
   endtask

   // ------------------------------------------------------------------
   // Driver: presents queued items, random gaps between them, with
   // stretches of back-to-back items. Steps the tracker on each accept.
   // ------------------------------------------------------------------
   midi_event_type  on_wire = '0;
   midi_event_type  next_ev;
   int              send_gap = 0;
   bit              steady_send = 1'b0;
   bit              hit;
   closed_note_type outcome;

   function automatic int pick_send_gap();
      int r;
      if ($urandom_range(0, 149) == 0) steady_send = !steady_send;
      if (steady_send) return 0;
      r = $urandom_range(0, 99);
      if (r < 55)      return 0;
      else if (r < 90) return $urandom_range(1, 3);
      else             return $urandom_range(4, 30);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            pair_event(on_wire, hit, outcome);
            if (hit) expected_notes.insert(expected_notes.size(), outcome);
         end
         if (!req_valid || !req_stall) begin
            if (send_gap != 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_events.size() != 0) begin
               next_ev           = pending_events.pop_front();
               on_wire          <= next_ev;
               req_valid        <= 1'b1;
               req_operation    <= next_ev.op;
               req_delta_ticks  <= next_ev.delta;
               req_pitch        <= next_ev.pitch;
               req_velocity     <= next_ev.velocity;
               req_damper_value <= next_ev.damper_value;
               send_gap         <= pick_send_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: random back-pressure, checks each accepted result against
   // the oldest expected one.
   // ------------------------------------------------------------------
   int              hold_left = 0;
   bit              steady_recv = 1'b0;
   int              stall_pick;
   closed_note_type seen;
   closed_note_type want;

   task automatic log_mismatch(input bit has_want, input closed_note_type w,
                               input closed_note_type g);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         if (has_want)
            $display({"%0t result mismatch: expected damper=%0d pitch=%0d vol=%0d",
                      " start=%0d stop=%0d"},
                     $realtime, w.is_damper, w.pitch, w.volume, w.start, w.stop);
         else
            $display("%0t result with nothing expected", $realtime);
         $display("   actual damper=%0d pitch=%0d vol=%0d start=%0d stop=%0d",
                  g.is_damper, g.pitch, g.volume, g.start, g.stop);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen.is_damper = rsp_is_damper;
            seen.pitch     = rsp_note_pitch;
            seen.volume    = rsp_note_volume;
            seen.start     = rsp_start_tick;
            seen.stop      = rsp_stop_tick;
            if (expected_notes.size() == 0) begin
               log_mismatch(1'b0, '0, seen);
            end else begin
               want = expected_notes.pop_front();
               if (seen !== want) log_mismatch(1'b1, want, seen);
            end
         end
         if ($urandom_range(0, 199) == 0) steady_recv <= !steady_recv;
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (steady_recv) begin
            rsp_stall <= 1'b0;
         end else begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 65) begin
               rsp_stall <= 1'b0;
            end else if (stall_pick < 93) begin
               rsp_stall <= 1'b1;
               hold_left <= $urandom_range(0, 2);
            end else begin
               rsp_stall <= 1'b1;
               hold_left <= $urandom_range(6, 30);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      for (int i = 0; i < NUM_PITCHES; i++) gen_open[i] = 1'b0;
      for (int i = 0; i < 16; i++) pitch_pool[i] = PITCH_W'($urandom());

      // directed: field extremes, every op, re-strike, pedal restart,
      // closes with nothing open, flush ignoring its delta
      add_event(OP_NOTE_ON,  '0,        7'd0,   7'd0,    1'b0);
      add_event(OP_NOTE_ON,  DELTA_TOP, 7'd127, 7'd127,  1'b1);
      add_event(OP_NOTE_OFF, 28'd1,     7'd0,   7'd0,    1'b0);
      add_event(OP_NOTE_ON,  28'd3,     7'd127, 7'h55,   1'b0); // re-strike
      add_event(OP_FLUSH,    DELTA_TOP, 7'd127, 7'd0,    1'b0); // delta unused
      add_event(OP_FLUSH,    28'd9,     7'd127, 7'd0,    1'b0); // already closed
      add_event(OP_NOTE_OFF, 28'd100,   7'd64,  7'd0,    1'b0); // nothing open
      add_event(OP_DAMPER,   28'd7,     7'd0,   7'd0,    1'b0); // pedal not down
      add_event(OP_DAMPER,   28'd10,    7'd0,   7'd0,    1'b1);
      add_event(OP_DAMPER,   28'd20,    7'd0,   7'd0,    1'b1); // restart
      add_event(OP_DAMPER,   28'd5,     7'd127, 7'd127,  1'b0);
      add_event(OP_NOTE_ON,  28'd0,     7'h2A,  7'h2A,   1'b0);
      add_event(OP_DAMPER,   28'd2,     7'd0,   7'd0,    1'b1);
      add_event(OP_NOTE_ON,  28'd9,     7'h55,  7'd1,    1'b0);
      add_event(OP_NOTE_OFF, 28'd4,     7'h2A,  7'd0,    1'b0);
      add_event(OP_DAMPER,   28'd0,     7'd0,   7'd0,    1'b0);
      add_event(OP_FLUSH,    28'd0,     7'h55,  7'd0,    1'b0);
      add_event(OP_FLUSH,    28'd0,     7'd0,   7'd0,    1'b0);
      add_event(OP_NOTE_OFF, 28'h5555555, 7'h55, 7'd0,   1'b0);
      add_event(OP_NOTE_ON,  28'hAAAAAAA, 7'd1, 7'd127,  1'b0);
      add_event(OP_NOTE_ON,  28'd0,     7'd2,   7'd0,    1'b0);
      add_event(OP_NOTE_OFF, 28'd1,     7'd2,   7'd0,    1'b0);
      add_event(OP_NOTE_OFF, 28'd1,     7'd1,   7'd0,    1'b0);

      for (int i = 0; i < RANDOM_LEN; i++) add_random_event(1'b0);
      // max deltas push the tick counter far up, then back to mixed deltas
      for (int i = 0; i < CLIMB_LEN; i++) add_random_event(1'b1);
      for (int i = 0; i < TAIL_LEN; i++) add_random_event(1'b0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_events.size() != 0 || req_valid) @(posedge clock);
      while (expected_notes.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

### midi_event_to_note_pairing_unit.f
hdl/mnp_pkg.sv
hdl/mnp_ram.sv
hdl/mnp_front.sv
hdl/mnp_queue.sv
hdl/mnp_back.sv
hdl/midi_event_to_note_pairing_unit.sv
sim/testbench.sv
